// ===== hdl/cft_pkg.sv =====
// ----------------------------------------------------------------------------
// cft_pkg
// Shared types and constants of the CSV field tokenizer.
// ----------------------------------------------------------------------------
package cft_pkg;

    // Character codes
    localparam logic [15:0] CH_QUOTE = 16'd34;
    localparam logic [15:0] CH_CR    = 16'd13;
    localparam logic [15:0] CH_LF    = 16'd10;
    localparam logic [15:0] CH_COMMA = 16'd44;

    // Result kinds
    localparam logic [1:0] KIND_DATA      = 2'd0;
    localparam logic [1:0] KIND_FIELD_END = 2'd1;
    localparam logic [1:0] KIND_REC_END   = 2'd2;
    localparam logic [1:0] KIND_EMPTY_REC = 2'd3;

    // Input commands
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_EOT  = 1'b1;

    // Saturation limit of the record counter
    localparam logic [30:0] REC_MAX = 31'h7FFF_FFFF;

    // Longest newline string inserted inside quotes
    localparam logic [1:0] NEWLINE_MAX = 2'd2;

    // Register map (index = paddr[3:2])
    localparam int unsigned   ADDR_W          = 4;
    localparam logic [1:0]    REG_SEPARATOR   = 2'd0;
    localparam logic [1:0]    REG_NL_LENGTH   = 2'd1;
    localparam logic [1:0]    REG_NL_FIRST    = 2'd2;
    localparam logic [1:0]    REG_NL_SECOND   = 2'd3;

    // Result queue
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned MAX_RESULTS = 3;

    typedef struct packed {
        logic        cmd;
        logic [15:0] char_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] char_out;
        logic [30:0] record_number;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] separator;
        logic [1:0]  newline_length;
        logic [15:0] newline_first;
        logic [15:0] newline_second;
    } t_cfg;

    // Results produced by one request, packed from slot 0
    typedef struct packed {
        logic [1:0]                   count;
        t_out_item [MAX_RESULTS-1:0]  slot;
    } t_push;

    // Queue status seen by the parser
    typedef struct packed {
        logic [2:0] free;
    } t_fifo_stat;

endpackage

// ===== hdl/cft_apb_regs.sv =====
// ----------------------------------------------------------------------------
// cft_apb_regs
// APB-style configuration registers: separator and inserted newline string.
// ----------------------------------------------------------------------------
module cft_apb_regs
    import cft_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.separator      <= CH_COMMA;
            r_cfg.newline_length <= 2'd2;
            r_cfg.newline_first  <= CH_CR;
            r_cfg.newline_second <= CH_LF;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SEPARATOR: r_cfg.separator      <= pwdata[15:0];
                REG_NL_LENGTH: r_cfg.newline_length <= pwdata[1:0];
                REG_NL_FIRST:  r_cfg.newline_first  <= pwdata[15:0];
                REG_NL_SECOND: r_cfg.newline_second <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_SEPARATOR: prdata = {16'd0, r_cfg.separator};
            REG_NL_LENGTH: prdata = {30'd0, r_cfg.newline_length};
            REG_NL_FIRST:  prdata = {16'd0, r_cfg.newline_first};
            REG_NL_SECOND: prdata = {16'd0, r_cfg.newline_second};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

// ===== hdl/cft_parse.sv =====
// ----------------------------------------------------------------------------
// cft_parse
// Input register, parser state and the per-character decode that yields
// zero to three results for each request.
// ----------------------------------------------------------------------------
module cft_parse
    import cft_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_in_item   i_data,
    output logic       o_stall,
    input  t_cfg       i_cfg,
    input  t_fifo_stat i_stat,
    output t_push      o_push
);

    typedef enum logic [2:0] {
        M_LINE   = 3'd0,
        M_FIELD  = 3'd1,
        M_PLAIN  = 3'd2,
        M_QUOTED = 3'd3,
        M_QBREAK = 3'd4,
        M_QSEEN  = 3'd5
    } t_mode;

    t_mode       r_mode, n_mode;
    logic        r_cr, n_cr;
    logic [30:0] r_rec, n_rec;
    logic        r_in_valid;
    t_in_item    r_in;

    logic        take, fits, advance;
    logic [30:0] rec_inc;
    logic        is_cr, is_lf, is_sep, is_quote;
    logic        en_nl, en_one;
    logic [1:0]  one_kind;
    logic [15:0] one_char;
    logic [30:0] one_rec;
    logic [1:0]  nl_len, n_nl, res_cnt;
    t_out_item   item_one, item_nl1, item_nl2;

    assign fits    = {1'b0, res_cnt} <= i_stat.free;
    assign advance = r_in_valid && fits;
    assign o_stall = r_in_valid && !fits;
    assign take    = i_valid && !o_stall;

    assign rec_inc  = (r_rec == REC_MAX) ? r_rec : r_rec + 31'd1;
    assign is_cr    = r_in.char_in == CH_CR;
    assign is_lf    = r_in.char_in == CH_LF;
    assign is_sep   = r_in.char_in == i_cfg.separator;
    assign is_quote = r_in.char_in == CH_QUOTE;

    // Decode one request against the current state
    always_comb begin
        n_mode   = r_mode;
        n_cr     = r_cr;
        n_rec    = r_rec;
        en_nl    = 1'b0;
        en_one   = 1'b0;
        one_kind = KIND_DATA;
        one_char = 16'd0;
        one_rec  = 31'd0;
        if (r_in.cmd == CMD_EOT) begin
            // close any open record, then start over
            en_nl = (r_mode == M_QUOTED);
            if (r_mode != M_LINE) begin
                en_one   = 1'b1;
                one_kind = KIND_REC_END;
                one_rec  = rec_inc;
            end
            n_mode = M_LINE;
            n_cr   = 1'b0;
            n_rec  = 31'd0;
        end else begin
            n_cr = is_cr;
            if (is_lf && r_cr) begin
                // LF of a CR-LF pair: already handled
            end else if (is_cr || is_lf) begin
                case (r_mode)
                    M_LINE: begin
                        en_one   = 1'b1;
                        one_kind = KIND_EMPTY_REC;
                        one_rec  = rec_inc;
                        n_rec    = rec_inc;
                    end
                    M_QUOTED, M_QBREAK: begin
                        en_nl  = 1'b1;
                        n_mode = M_QBREAK;
                    end
                    default: begin
                        en_one   = 1'b1;
                        one_kind = KIND_REC_END;
                        one_rec  = rec_inc;
                        n_rec    = rec_inc;
                        n_mode   = M_LINE;
                    end
                endcase
            end else begin
                case (r_mode)
                    M_LINE, M_FIELD: begin
                        if (is_quote) begin
                            n_mode = M_QUOTED;
                        end else if (is_sep) begin
                            en_one   = 1'b1;
                            one_kind = KIND_FIELD_END;
                            n_mode   = M_FIELD;
                        end else begin
                            en_one   = 1'b1;
                            one_char = r_in.char_in;
                            n_mode   = M_PLAIN;
                        end
                    end
                    M_PLAIN: begin
                        en_one = 1'b1;
                        if (is_sep) begin
                            one_kind = KIND_FIELD_END;
                            n_mode   = M_FIELD;
                        end else begin
                            one_char = r_in.char_in;
                        end
                    end
                    M_QUOTED, M_QBREAK: begin
                        if (is_quote) begin
                            n_mode = M_QSEEN;
                        end else begin
                            en_one   = 1'b1;
                            one_char = r_in.char_in;
                            n_mode   = M_QUOTED;
                        end
                    end
                    default: begin
                        // just after a closing quote
                        en_one = 1'b1;
                        if (is_quote) begin
                            one_char = CH_QUOTE;
                            n_mode   = M_QUOTED;
                        end else if (is_sep) begin
                            one_kind = KIND_FIELD_END;
                            n_mode   = M_FIELD;
                        end else begin
                            one_char = r_in.char_in;
                            n_mode   = M_PLAIN;
                        end
                    end
                endcase
            end
        end
    end

    // Pack newline characters first, then the single result
    assign nl_len  = (i_cfg.newline_length > NEWLINE_MAX) ? NEWLINE_MAX
                                                          : i_cfg.newline_length;
    assign n_nl    = en_nl ? nl_len : 2'd0;
    assign res_cnt = n_nl + {1'b0, en_one};

    assign item_one = '{kind: one_kind, char_out: one_char, record_number: one_rec,
                        last: 1'b0};
    assign item_nl1 = '{kind: KIND_DATA, char_out: i_cfg.newline_first,
                        record_number: 31'd0, last: 1'b0};
    assign item_nl2 = '{kind: KIND_DATA, char_out: i_cfg.newline_second,
                        record_number: 31'd0, last: 1'b0};

    always_comb begin
        o_push.count   = advance ? res_cnt : 2'd0;
        o_push.slot[0] = (n_nl >= 2'd1) ? item_nl1 : item_one;
        o_push.slot[1] = (n_nl >= 2'd2) ? item_nl2 : item_one;
        o_push.slot[2] = item_one;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            o_push.slot[i].last = (res_cnt == 2'(i + 1));
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= M_LINE;
            r_cr       <= 1'b0;
            r_rec      <= 31'd0;
        end else begin
            if (take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_mode <= n_mode;
                r_cr   <= n_cr;
                r_rec  <= n_rec;
            end
        end
    end

    // Input payload register
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in <= i_data;
        end
    end

endmodule

// ===== hdl/cft_result_fifo.sv =====
// ----------------------------------------------------------------------------
// cft_result_fifo
// Small result queue: takes up to three results a cycle, hands out one while i_stall is low.
// ----------------------------------------------------------------------------
module cft_result_fifo
    import cft_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_push      i_push,
    output t_fifo_stat o_stat,
    output logic       o_valid,
    output t_out_item  o_data,
    input  logic       i_stall
);

    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);

    t_out_item        r_q [FIFO_DEPTH];
    logic [PTR_W-1:0] r_head, r_tail;
    logic [2:0]       r_count;
    logic             pop;

    assign o_valid     = r_count != 3'd0;
    assign o_data      = r_q[r_head];
    assign pop         = o_valid && !i_stall;
    assign o_stat.free = 3'(FIFO_DEPTH) - r_count + {2'd0, pop};

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= 3'd0;
        end else begin
            r_tail  <= r_tail + PTR_W'(i_push.count);
            r_head  <= r_head + PTR_W'(pop);
            r_count <= r_count + {1'b0, i_push.count} - {2'd0, pop};
        end
    end

    // Entry writes
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (2'(i) < i_push.count) begin
                r_q[r_tail + PTR_W'(i)] <= i_push.slot[i];
            end
        end
    end

endmodule

// ===== hdl/csv_field_tokenizer.sv =====
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// Streaming CSV tokenizer over 16-bit characters with quoted fields.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall / i_data): one character, or an
//   end-of-text mark that closes an open record and resets the parser.
//   Output channel (o_valid / i_stall / o_data): data characters, field
//   ends, record ends and empty records; last marks the final result of
//   each request. Configuration goes through the APB-style port; the user
//   must write it only while the block is idle; the block does not enforce it.
//   A request is held in the input register, and its results enter a
//   four-entry queue once it has room for all of them; the first result
//   is then handed out from the queue.
//   Throughput: one request per cycle while each gives at most one result
//   and the queue has room. A request giving two or three results (a line
//   break or end of text inside quotes) holds the input register until the
//   queue has room for all of them; the queue drains one result per cycle
//   while i_stall is low. Reset clears parser state, the record count and
//   the queue, and loads the register defaults. While i_stall is high the
//   queue fills and then o_stall rises; nothing is lost.
// ----------------------------------------------------------------------------
module csv_field_tokenizer
    import cft_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_in_item          i_data,
    output logic              o_stall,
    output logic              o_valid,
    output t_out_item         o_data,
    input  logic              i_stall,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg       cfg;
    t_push      push;
    t_fifo_stat stat;

    cft_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cft_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .i_cfg   (cfg),
        .i_stat  (stat),
        .o_push  (push)
    );

    cft_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_stat  (stat),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

endmodule

// ===== hdl/cft_checker.sv =====
// ----------------------------------------------------------------------------
// cft_checker
// Port-level checks of the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module cft_checker
    import cft_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_stall,
    input logic              o_valid,
    input t_out_item         o_data,
    input logic              i_stall
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    // Only record ends and empty records carry a record number, and it is never zero
    a_rec_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_data.kind == KIND_DATA || o_data.kind == KIND_FIELD_END)
                     ? (o_data.record_number == 31'd0)
                     : (o_data.record_number != 31'd0)))
        else $error("record number does not match result kind");

    // Non-data results carry no character
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.kind != KIND_DATA) |-> o_data.char_out == 16'd0)
        else $error("character on a non-data result");

    // Input register and queue are empty right after reset
    a_no_stall_after_rst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_stall && !o_valid)
        else $error("busy right after reset");

endmodule

bind csv_field_tokenizer cft_checker u_cft_checker (.*);

// ===== tb/sv/tb_csv_field_tokenizer.sv =====
// ----------------------------------------------------------------------------
// tb_csv_field_tokenizer
// Self-checking testbench of the streaming CSV field tokenizer.
// ----------------------------------------------------------------------------
// A queue of pending requests feeds a clocked driver that sends them in bursts
// with random gaps. Every accepted request runs through a behavioral tokenizer
// that tracks parse mode, the pending CR and the record count, and queues the
// results it should give. A clocked monitor stalls the output on a pattern of
// its own and checks each result against the oldest queued expectation. A
// directed opener hits quoting, line-end and end-of-text corner cases. Then
// several register settings follow, each with random well-formed records mixed
// with noise.
// ----------------------------------------------------------------------------
module tb_csv_field_tokenizer;
    import cft_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 55;
    localparam int N_PHASES     = 8;

    typedef enum logic [2:0] {
        PM_LINE, PM_FIELD, PM_PLAIN, PM_QUOTED, PM_QBREAK, PM_QSEEN
    } t_parse_mode;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    t_in_item          i_data  = '0;
    logic              o_stall;
    logic              o_valid;
    t_out_item         o_data;
    logic              i_stall = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    csv_field_tokenizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Register copies and tokenizer state of the behavioral model
    logic [15:0] cfg_sep       = CH_COMMA;
    logic [1:0]  cfg_nl_len    = 2'd2;
    logic [15:0] cfg_nl_first  = CH_CR;
    logic [15:0] cfg_nl_second = CH_LF;
    t_parse_mode pmode         = PM_LINE;
    logic        cr_pend       = 1'b0;
    logic [30:0] rec_cnt       = '0;

    t_in_item  pend_q[$];     // requests waiting for the driver
    t_out_item token_q[$];    // tokens still owed by the block
    t_out_item step_q[$];     // tokens of the request being predicted

    int  err_cnt    = 0;
    int  n_sent     = 0;
    int  n_eot      = 0;
    int  n_tokens   = 0;
    int  n_settings = 1;
    int  gen_cnt    = 0;
    int  cycle_cnt  = 0;
    int  burst_left = 1;
    int  gap_left   = 0;
    int  stall_run  = 0;
    bit  stall_hold = 1'b0;
    bit  idle_on    = 1'b1;

    // ------------------------------------------------------------------
    // Behavioral tokenizer
    // ------------------------------------------------------------------
    function automatic void add_token(logic [1:0] kind, logic [15:0] ch, logic [30:0] rec);
        t_out_item r;
        r.kind          = kind;
        r.char_out      = ch;
        r.record_number = rec;
        r.last          = 1'b0;
        step_q.push_back(r);
    endfunction

    function automatic void close_record(logic [1:0] kind);
        if (rec_cnt != REC_MAX) rec_cnt++;
        pmode = PM_LINE;
        add_token(kind, '0, rec_cnt);
    endfunction

    // Newline string inserted for a line break inside quotes; length 3 saturates
    function automatic void add_newline();
        logic [1:0] n;
        n = (cfg_nl_len > NEWLINE_MAX) ? NEWLINE_MAX : cfg_nl_len;
        if (n >= 2'd1) add_token(KIND_DATA, cfg_nl_first, '0);
        if (n >= 2'd2) add_token(KIND_DATA, cfg_nl_second, '0);
    endfunction

    task automatic predict_tokens(input t_in_item req);
        logic [15:0] c;
        logic        was_cr;
        t_parse_mode m;
        step_q.delete();
        m = pmode;
        if (req.cmd == CMD_EOT) begin
            // close any open record, then clear everything
            if (m == PM_QUOTED) add_newline();
            if (m != PM_LINE) close_record(KIND_REC_END);
            pmode   = PM_LINE;
            cr_pend = 1'b0;
            rec_cnt = '0;
        end else begin
            c       = req.char_in;
            was_cr  = cr_pend;
            cr_pend = (c == CH_CR);
            // LF right after CR is the tail of CR-LF: swallowed
            if (!(c == CH_LF && was_cr)) begin
                if (c == CH_CR || c == CH_LF) begin
                    if (m == PM_LINE) begin
                        close_record(KIND_EMPTY_REC);
                    end else if (m == PM_QUOTED || m == PM_QBREAK) begin
                        add_newline();
                        pmode = PM_QBREAK;
                    end else begin
                        close_record(KIND_REC_END);
                    end
                end else begin
                    case (m)
                        PM_LINE, PM_FIELD: begin
                            if (c == CH_QUOTE) begin
                                pmode = PM_QUOTED;
                            end else if (c == cfg_sep) begin
                                add_token(KIND_FIELD_END, '0, '0);
                                pmode = PM_FIELD;
                            end else begin
                                add_token(KIND_DATA, c, '0);
                                pmode = PM_PLAIN;
                            end
                        end
                        PM_PLAIN: begin
                            if (c == cfg_sep) begin
                                add_token(KIND_FIELD_END, '0, '0);
                                pmode = PM_FIELD;
                            end else begin
                                add_token(KIND_DATA, c, '0);
                            end
                        end
                        PM_QUOTED, PM_QBREAK: begin
                            if (c == CH_QUOTE) begin
                                pmode = PM_QSEEN;
                            end else begin
                                add_token(KIND_DATA, c, '0);
                                pmode = PM_QUOTED;
                            end
                        end
                        default: begin
                            // quote just seen inside a quoted field
                            if (c == CH_QUOTE) begin
                                add_token(KIND_DATA, CH_QUOTE, '0);
                                pmode = PM_QUOTED;
                            end else if (c == cfg_sep) begin
                                add_token(KIND_FIELD_END, '0, '0);
                                pmode = PM_FIELD;
                            end else begin
                                add_token(KIND_DATA, c, '0);
                                pmode = PM_PLAIN;
                            end
                        end
                    endcase
                end
            end
        end
        if (step_q.size() != 0) step_q[step_q.size()-1].last = 1'b1;
        foreach (step_q[i]) token_q.push_back(step_q[i]);
    endtask

    // ------------------------------------------------------------------
    // Request driver: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_tokens(i_data);
                n_sent++;
                if (i_data.cmd == CMD_EOT) n_eot++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pend_q.size() != 0) begin
                    i_data  <= pend_q.pop_front();
                    i_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = (!idle_on || $urandom_range(0, 3) == 0) ? 0 :
                                     $urandom_range(1, 5);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and output stall pattern
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                n_tokens++;
                if (token_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("[%0t] unexpected result: kind %0d char %h rec %0d last %0b",
                                 $realtime, o_data.kind, o_data.char_out,
                                 o_data.record_number, o_data.last);
                end else begin
                    want = token_q.pop_front();
                    if (o_data.kind !== want.kind || o_data.char_out !== want.char_out ||
                        o_data.record_number !== want.record_number ||
                        o_data.last !== want.last) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display({"[%0t] mismatch: kind %0d/%0d char %h/%h ",
                                      "rec %0d/%0d last %0b/%0b (got/exp)"},
                                     $realtime, o_data.kind, want.kind,
                                     o_data.char_out, want.char_out,
                                     o_data.record_number, want.record_number,
                                     o_data.last, want.last);
                    end
                end
            end
            // alternate stall runs and free runs
            if (stall_run == 0) begin
                stall_hold = idle_on && ($urandom_range(0, 2) == 0);
                stall_run  = stall_hold ? $urandom_range(1, 6) : $urandom_range(1, 24);
            end
            stall_run--;
            i_stall <= stall_hold;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, token_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_char(input logic [15:0] c);
        t_in_item r;
        r.cmd     = CMD_CHAR;
        r.char_in = c;
        pend_q.push_back(r);
        gen_cnt++;
    endtask

    task automatic push_eot();
        t_in_item r;
        r.cmd     = CMD_EOT;
        r.char_in = 16'($urandom_range(0, 65535));
        pend_q.push_back(r);
        gen_cnt++;
    endtask

    function automatic logic [15:0] text_char();
        return ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) :
                                             16'($urandom_range(97, 122));
    endfunction

    task automatic push_line_end();
        case ($urandom_range(0, 2))
            0: push_char(CH_CR);
            1: push_char(CH_LF);
            default: begin
                push_char(CH_CR);
                push_char(CH_LF);
            end
        endcase
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_SEPARATOR: cfg_sep       = val[15:0];
            REG_NL_LENGTH: cfg_nl_len    = val[1:0];
            REG_NL_FIRST:  cfg_nl_first  = val[15:0];
            default:       cfg_nl_second = val[15:0];
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] sep, input logic [1:0] len,
                              input logic [15:0] nl1, input logic [15:0] nl2);
        write_reg(REG_SEPARATOR, 32'(sep));
        write_reg(REG_NL_LENGTH, 32'(len));
        write_reg(REG_NL_FIRST, 32'(nl1));
        write_reg(REG_NL_SECOND, 32'(nl2));
        n_settings++;
    endtask

    // Mostly well-formed records with random content, some noise
    task automatic fill_random(input int n_items);
        int stop_at;
        int nf;
        int len;
        stop_at = gen_cnt + n_items;
        while (gen_cnt < stop_at) begin
            if ($urandom_range(0, 6) == 0) begin
                len = $urandom_range(1, 6);
                repeat (len) begin
                    case ($urandom_range(0, 5))
                        0: push_char(CH_QUOTE);
                        1: push_char(CH_CR);
                        2: push_char(CH_LF);
                        3: push_char(cfg_sep);
                        4: push_char(16'($urandom_range(0, 65535)));
                        default: push_char(text_char());
                    endcase
                end
                if ($urandom_range(0, 3) == 0) push_eot();
            end else begin
                nf = $urandom_range(1, 4);
                for (int k = 0; k < nf; k++) begin
                    if (k > 0) push_char(cfg_sep);
                    case ($urandom_range(0, 4))
                        0, 1: begin
                            len = $urandom_range(0, 4);
                            repeat (len) push_char(text_char());
                        end
                        2, 3: begin
                            push_char(CH_QUOTE);
                            len = $urandom_range(0, 5);
                            repeat (len) begin
                                case ($urandom_range(0, 9))
                                    0, 1: begin
                                        push_char(CH_QUOTE);
                                        push_char(CH_QUOTE);
                                    end
                                    2: push_char(cfg_sep);
                                    3, 4: push_line_end();
                                    default: push_char(text_char());
                                endcase
                            end
                            push_char(CH_QUOTE);
                            // trailing text after the closing quote
                            if ($urandom_range(0, 3) == 0) push_char(text_char());
                        end
                        default: ;  // empty field
                    endcase
                end
                if ($urandom_range(0, 9) == 0) begin
                    push_eot();
                end else begin
                    push_line_end();
                    if ($urandom_range(0, 9) == 0) push_line_end();
                end
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pend_q.size() != 0 || i_valid || token_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opener at reset register values
        push_char(16'h0061);        // plain data
        push_char(CH_COMMA);        // field end
        push_char(CH_QUOTE);        // open quoted field
        push_char(16'h0078);
        push_char(CH_QUOTE);        // doubled quote gives one quote
        push_char(CH_QUOTE);
        push_char(CH_COMMA);        // separator is data inside quotes
        push_char(CH_CR);           // line break inside quotes
        push_char(CH_LF);           // swallowed half of CR-LF
        push_char(16'h0079);
        push_char(CH_QUOTE);        // close
        push_char(16'h007A);        // text after closing quote is kept
        push_char(CH_COMMA);
        push_char(CH_CR);           // trailing separator then line end
        push_char(16'h0000);        // char after CR is not dropped
        push_char(16'hFFFF);
        push_char(CH_LF);
        push_char(CH_LF);           // empty line
        push_char(CH_QUOTE);
        push_char(16'h7FFF);
        push_eot();                 // end of text inside quotes with chars
        push_eot();                 // end of text at line start
        push_char(CH_QUOTE);
        push_char(CH_LF);
        push_eot();                 // end of text right after a quoted break
        push_char(16'h8000);
        push_char(CH_COMMA);
        push_eot();                 // end of text after a trailing separator
        wait_drained();

        // Random phases over a range of register settings
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: set_config(CH_COMMA, 2'd2, CH_CR, CH_LF);
                1: set_config(16'd59, 2'd1, CH_LF, 16'hFFFF);
                2: set_config(16'hFFFF, 2'd0, 16'h0000, 16'h0000);
                3: set_config(16'h0000, 2'd3, 16'hFFFF, 16'h8001);
                4: set_config(CH_QUOTE, 2'd2, 16'h00A5, 16'h5A00);  // quote separates after plain text
                5: set_config(CH_CR, 2'd1, 16'h2028, 16'h0000);     // line end wins
                6: set_config(CH_LF, 2'd2, 16'h7FFF, 16'h0001);
                default: set_config(16'($urandom_range(0, 65535)),
                                    2'($urandom_range(0, 3)),
                                    16'($urandom_range(0, 65535)),
                                    16'($urandom_range(0, 65535)));
            endcase
            idle_on = (ph != 1);
            fill_random(PHASE_ITEMS);
            wait_drained();
        end

        $display("Sent %0d requests (%0d end-of-text) and checked %0d results",
                 n_sent, n_eot, n_tokens);
        $display("over %0d register settings, with and without idle on both channels",
                 n_settings);
        if (token_q.size() != 0) begin
            err_cnt++;
            $display("%0d expected results never arrived", token_q.size());
        end
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/cft_pkg.sv
hdl/cft_apb_regs.sv
hdl/cft_parse.sv
hdl/cft_result_fifo.sv
hdl/csv_field_tokenizer.sv
hdl/cft_checker.sv
tb/sv/tb_csv_field_tokenizer.sv
